// ===== src/ascending_value_sorter_core_assert.svh =====
// Assertion macros used by the sorter checker file.
`ifndef ASCENDING_VALUE_SORTER_CORE_ASSERT_SVH
`define ASCENDING_VALUE_SORTER_CORE_ASSERT_SVH

// Same-cycle implication, held off during reset.
`define AVS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off during reset.
`define AVS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/avs_pkg.sv =====
// Types and constants of the ascending value sorter.
`default_nettype none

package avs_pkg;

    localparam int DEPTH_DEF = 32;
    localparam int VAL_W     = 32;

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic                    last_in;
    } in_item_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] sorted_value;
        logic                    last_out;
        logic                    overflow;
    } out_item_t;

    typedef enum logic {
        ST_LOAD,
        ST_SCAN
    } avs_state_t;

endpackage

`default_nettype wire

// ===== src/avs_ram.sv =====
// Generic simple dual-port RAM with registered read data.
`default_nettype none

module avs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== src/ascending_value_sorter_core.sv =====
// Loading: one item per cycle while the core is in its load state; after the last item, each result
// needs one RAM read per held value through the single compare unit, and waits while the output stalls.
// Sets: the next set is taken only once every result of this set has been emitted; the RAM read port
// and the one signed comparator bound the scan for each result.
// Reset: asynchronous, active low; clears the fill count, overflow flag and sequencer,
// the value store is not cleared and only entries written in the current set are read.
`default_nettype none

module ascending_value_sorter_core #(
    parameter int DEPTH = avs_pkg::DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load_valid,
    output logic              load_stall,
    input  avs_pkg::in_item_t load_item,
    output logic              result_valid,
    input  logic              result_stall,
    output avs_pkg::out_item_t result_item
);

    import avs_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    avs_state_t state_reg, state_next;

    logic [CW-1:0]           fill_reg, fill_next;
    logic                    drop_reg, drop_next;
    logic [CW-1:0]           rd_idx_reg, rd_idx_next;
    logic                    cmp_vld_reg, cmp_vld_next;
    logic [AW-1:0]           cmp_idx_reg, cmp_idx_next;
    logic signed [VAL_W-1:0] best_val_reg, best_val_next;
    logic [AW-1:0]           best_idx_reg, best_idx_next;
    logic                    found_reg, found_next;
    logic [CW-1:0]           emit_cnt_reg, emit_cnt_next;
    logic [DEPTH-1:0]        taken_reg, taken_next;
    logic                    out_valid_reg, out_valid_next;
    out_item_t               out_item_reg, out_item_next;

    logic                    ram_we;
    logic [AW-1:0]           ram_waddr;
    logic [AW-1:0]           ram_raddr;
    logic [VAL_W-1:0]        ram_rdata;
    logic signed [VAL_W-1:0] rdata_s;

    logic load_accept;
    logic room;
    logic issue;
    logic done;
    logic emit;
    logic emit_last;
    logic better;

    avs_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (load_item.value),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rdata_s      = ram_rdata;
    assign result_valid = out_valid_reg;
    assign result_item  = out_item_reg;

    assign load_accept = load_valid && !load_stall;
    assign room        = (fill_reg < CW'(DEPTH));
    assign done        = (state_reg == ST_SCAN) && (rd_idx_reg == fill_reg) && !cmp_vld_reg;
    assign emit        = done && (!out_valid_reg || !result_stall);
    assign emit_last   = (CW'(emit_cnt_reg + CW'(1)) == fill_reg);
    assign better      = cmp_vld_reg && !taken_reg[cmp_idx_reg]
                         && (!found_reg || (rdata_s < best_val_reg));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (load_accept && load_item.last_in)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (emit && emit_last)
                begin
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // Outputs of the sequencer
    always_comb
    begin
        load_stall = 1'b1;
        ram_we     = 1'b0;
        issue      = 1'b0;
        case (state_reg)
            ST_LOAD:
            begin
                load_stall = 1'b0;
                ram_we     = load_valid && room;
            end
            ST_SCAN:
            begin
                issue = (rd_idx_reg < fill_reg);
            end
            default:
            begin
                load_stall = 1'b1;
            end
        endcase
    end

    assign ram_waddr = fill_reg[AW-1:0];
    assign ram_raddr = rd_idx_reg[AW-1:0];

    // Datapath
    always_comb
    begin
        fill_next      = fill_reg;
        drop_next      = drop_reg;
        rd_idx_next    = rd_idx_reg;
        cmp_vld_next   = 1'b0;
        cmp_idx_next   = cmp_idx_reg;
        best_val_next  = best_val_reg;
        best_idx_next  = best_idx_reg;
        found_next     = found_reg;
        emit_cnt_next  = emit_cnt_reg;
        taken_next     = taken_reg;
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;

        if (out_valid_reg && !result_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (load_accept)
        begin
            if (room)
            begin
                fill_next = CW'(fill_reg + CW'(1));
            end
            else
            begin
                drop_next = 1'b1;
            end
            if (load_item.last_in)
            begin
                // open a fresh selection pass over the whole set
                rd_idx_next   = '0;
                found_next    = 1'b0;
                emit_cnt_next = '0;
                taken_next    = '0;
            end
        end

        if (issue)
        begin
            rd_idx_next  = CW'(rd_idx_reg + CW'(1));
            cmp_vld_next = 1'b1;
            cmp_idx_next = rd_idx_reg[AW-1:0];
        end

        if (better)
        begin
            best_val_next = rdata_s;
            best_idx_next = cmp_idx_reg;
            found_next    = 1'b1;
        end

        if (emit)
        begin
            out_valid_next             = 1'b1;
            out_item_next.sorted_value = best_val_reg;
            out_item_next.last_out     = emit_last;
            out_item_next.overflow     = drop_reg;
            taken_next[best_idx_reg]   = 1'b1;
            emit_cnt_next              = CW'(emit_cnt_reg + CW'(1));
            rd_idx_next                = '0;
            found_next                 = 1'b0;
            if (emit_last)
            begin
                fill_next = '0;
                drop_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            fill_reg      <= '0;
            drop_reg      <= 1'b0;
            rd_idx_reg    <= '0;
            cmp_vld_reg   <= 1'b0;
            found_reg     <= 1'b0;
            emit_cnt_reg  <= '0;
            taken_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            drop_reg      <= drop_next;
            rd_idx_reg    <= rd_idx_next;
            cmp_vld_reg   <= cmp_vld_next;
            found_reg     <= found_next;
            emit_cnt_reg  <= emit_cnt_next;
            taken_reg     <= taken_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_idx_reg  <= cmp_idx_next;
        best_val_reg <= best_val_next;
        best_idx_reg <= best_idx_next;
        out_item_reg <= out_item_next;
    end

endmodule

`default_nettype wire

// ===== src/avs_checker.sv =====
// Port-level checker for the sorter core, bound into the sorter core module.
`default_nettype none

`include "ascending_value_sorter_core_assert.svh"

module avs_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               load_valid,
    input logic               load_stall,
    input avs_pkg::in_item_t  load_item,
    input logic               result_valid,
    input logic               result_stall,
    input avs_pkg::out_item_t result_item
);

    logic last_taken;
    logic mid_result_taken;
    logic result_held;

    assign last_taken       = load_valid && !load_stall && load_item.last_in;
    assign mid_result_taken = result_valid && !result_stall && !result_item.last_out;
    assign result_held      = result_valid && result_stall;

    // Hold a stalled result and its payload.
    `AVS_ASSERT_NEXT(a_result_hold, clk, rst_n, result_held, result_valid && $stable(result_item), "stalled result item changed")
    // Stop taking items once a set has closed.
    `AVS_ASSERT_NEXT(a_busy_after_last, clk, rst_n, last_taken, load_stall, "input taken right after the closing item")
    // Keep the input stalled while a set is still being emitted.
    `AVS_ASSERT_NOW(a_busy_mid_set, clk, rst_n, mid_result_taken, load_stall, "input open before the set was fully emitted")

endmodule

bind ascending_value_sorter_core avs_checker u_avs_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .load_valid   (load_valid),
    .load_stall   (load_stall),
    .load_item    (load_item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_item  (result_item)
);

`default_nettype wire
